### src/midi_track_event_parser_core_macros.svh
// assertion macros for the track event parser checker
`ifndef MIDI_TRACK_EVENT_PARSER_CORE_MACROS_SVH
`define MIDI_TRACK_EVENT_PARSER_CORE_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define MTEP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mtep check failed");

// next-cycle implication checked outside reset
`define MTEP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mtep check failed");

`endif

### src/mtep_pkg.sv
// shared types and constants for the track event parser
`timescale 1ns / 1ps
package mtep_pkg;

    localparam int MAX_LENGTH_BYTES = 4;
    localparam int LEN_CNT_W = 3;

    typedef enum logic [2:0] {
        KIND_CHANNEL   = 3'd0,
        KIND_FIXED     = 3'd1,
        KIND_META_HDR  = 3'd2,
        KIND_SYSEX     = 3'd3,
        KIND_DIV_SYSEX = 3'd4,
        KIND_PAYLOAD   = 3'd5,
        KIND_ERROR     = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_UNKNOWN    = 3'd1,
        ERR_META_LEN   = 3'd2,
        ERR_NO_RUNNING = 3'd3,
        ERR_OVERLONG   = 3'd4
    } err_t;

    localparam logic [7:0] META_SEQ     = 8'h00;
    localparam logic [7:0] META_CHAN    = 8'h20;
    localparam logic [7:0] META_EOT     = 8'h2F;
    localparam logic [7:0] META_TEMPO   = 8'h51;
    localparam logic [7:0] META_SMPTE   = 8'h54;
    localparam logic [7:0] META_TIMESIG = 8'h58;
    localparam logic [7:0] META_KEYSIG  = 8'h59;

    // result item; the first field listed sits highest in tdata, kind lowest
    typedef struct packed {
        logic [2:0]  error_code;
        logic        last_of_event;
        logic [27:0] wide_value;
        logic [7:0]  field_e;
        logic [7:0]  field_d;
        logic [7:0]  field_c;
        logic [7:0]  field_b;
        logic [7:0]  field_a;
        logic [7:0]  meta_kind;
        logic [7:0]  status_byte;
        logic [27:0] delta_ticks;
        logic [2:0]  kind;
    } result_t;

    // fixed meta length, valid flag clear for variable-length subtypes
    function automatic logic [3:0] fixed_len(input logic [7:0] meta);
        logic [3:0] r;
        r = 4'd0;
        case (meta)
            META_SEQ:     r = 4'b1010;
            META_CHAN:    r = 4'b1001;
            META_EOT:     r = 4'b1000;
            META_TEMPO:   r = 4'b1011;
            META_SMPTE:   r = 4'b1101;
            META_TIMESIG: r = 4'b1100;
            META_KEYSIG:  r = 4'b1010;
            default:      r = 4'b0000;
        endcase
        return r;
    endfunction

    function automatic logic [27:0] smpte_rate(input logic [1:0] code);
        logic [27:0] r;
        r = 28'd24;
        case (code)
            2'd0:    r = 28'd24;
            2'd1:    r = 28'd25;
            2'd2:    r = 28'd29;
            default: r = 28'd30;
        endcase
        return r;
    endfunction

endpackage

### src/midi_track_event_parser_core.sv
// top level of the standard midi file track event parser
//
// s_axis carries one track-chunk body byte per request: tdata = data_byte,
// tuser = track_start (set on the first byte of a track). m_axis carries at
// most one result per input byte. The parse state advances one byte per
// cycle while s_axis_tready is high, through a small phase register; all
// work for a byte sits between the input handshake and the output
// register, so a result appears in the cycle after the byte that caused it.
// Sustained throughput is one byte per cycle as long as m_axis_tready is
// high. s_axis_tready falls only when the output register holds a result
// the receiver has not taken; then input waits and nothing is lost.
// Errors give an error result and the block drops bytes silently until a
// byte with track_start set arrives. Reset clears the parse phase, running
// status, halt flag and the output valid; no clearing pass is needed.
// tdata of m_axis: kind, delta_ticks, status_byte, meta_kind, field_a..e,
// wide_value, last_of_event, error_code, from the lowest bit up, padded
// with zeros to 120 bits.
`timescale 1ns / 1ps
module midi_track_event_parser_core
    import mtep_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // data_byte
    input  logic         s_axis_tuser,   // track_start
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [119:0] m_axis_tdata    // kind, delta_ticks, status_byte, meta_kind,
                                         // field_a..field_e, wide_value,
                                         // last_of_event, error_code
);

    typedef enum logic [3:0] {
        PH_DELTA, PH_STATUS, PH_PARAM1, PH_PARAM2, PH_META_TYPE,
        PH_META_LEN, PH_SYSEX_LEN, PH_GATHER, PH_PAYLOAD
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [7:0]           running_reg, running_next;
    logic [27:0]          delta_reg, delta_next;
    logic [27:0]          len_reg, len_next;
    logic [LEN_CNT_W-1:0] lcnt_reg, lcnt_next;
    logic [7:0]           cur_status_reg, cur_status_next;
    logic [7:0]           cur_meta_reg, cur_meta_next;
    logic [2:0]           fidx_reg, fidx_next;
    logic [7:0]           g_reg [5];
    logic [7:0]           g_next [5];
    logic                 halted_reg, halted_next;
    logic                 out_valid_reg;
    result_t              out_reg;
    result_t              res;
    logic                 emit;

    logic                 accept;
    logic [7:0]           b;
    logic                 ts;
    logic                 vlq_cont;
    logic                 vlq_over;
    logic [27:0]          vlq_base;
    logic [27:0]          vlq_acc;
    logic [3:0]           flen;
    logic [27:0]          len_dec;
    logic [2:0]           fidx_inc;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign b = s_axis_tdata;
    assign ts = s_axis_tuser;

    always_comb
    begin
        phase_t    ph;
        logic [LEN_CNT_W-1:0] lc;
        logic [2:0] n;
        ph = ts ? PH_DELTA : phase_reg;
        lc = ts ? '0 : lcnt_reg;

        phase_next = ph;
        running_next = ts ? 8'h00 : running_reg;
        delta_next = delta_reg;
        len_next = len_reg;
        lcnt_next = lc;
        cur_status_next = cur_status_reg;
        cur_meta_next = cur_meta_reg;
        fidx_next = fidx_reg;
        for (int i = 0; i < 5; i++)
        begin
            g_next[i] = g_reg[i];
        end
        halted_next = ts ? 1'b0 : halted_reg;
        emit = 1'b0;
        res = '0;
        flen = fixed_len(cur_meta_reg);
        fidx_inc = fidx_reg + 3'd1;
        len_dec = len_reg - 28'd1;
        n = 3'd0;

        vlq_base = (lc == '0) ? 28'd0 : ((ph == PH_DELTA) ? delta_reg : len_reg);
        vlq_acc = {vlq_base[20:0], b[6:0]};
        vlq_cont = b[7];
        vlq_over = b[7] && ({1'b0, lc} + 4'd1 >= 4'(MAX_LENGTH_BYTES));

        if (!halted_next)
        begin
            unique case (ph)
                PH_DELTA:
                begin
                    if (lc == '0)
                    begin
                        cur_status_next = 8'h00;
                        cur_meta_next = 8'h00;
                    end
                    delta_next = vlq_acc;
                    lcnt_next = vlq_cont ? lc + 1'b1 : '0;
                    if (vlq_over)
                        n = ERR_OVERLONG;
                    else if (!vlq_cont)
                        phase_next = PH_STATUS;
                end
                PH_STATUS:
                begin
                    if (b == 8'hFF)
                    begin
                        cur_status_next = b;
                        phase_next = PH_META_TYPE;
                    end
                    else if (b == 8'hF0 || b == 8'hF7)
                    begin
                        cur_status_next = b;
                        lcnt_next = '0;
                        phase_next = PH_SYSEX_LEN;
                    end
                    else if (b[7:4] == 4'hF)
                    begin
                        cur_status_next = b;
                        n = ERR_UNKNOWN;
                    end
                    else if (b[7])
                    begin
                        cur_status_next = b;
                        running_next = b;
                        phase_next = PH_PARAM1;
                    end
                    else if (running_next == 8'h00)
                        n = ERR_NO_RUNNING;
                    else
                    begin
                        cur_status_next = running_next;
                        g_next[0] = b;
                        if (running_next[7:4] == 4'hC || running_next[7:4] == 4'hD)
                        begin
                            phase_next = PH_DELTA;
                            emit = 1'b1;
                            res.field_a = b;
                            res.field_b = 8'hFF;
                        end
                        else
                            phase_next = PH_PARAM2;
                    end
                end
                PH_PARAM1:
                begin
                    g_next[0] = b;
                    if (cur_status_reg[7:4] == 4'hC || cur_status_reg[7:4] == 4'hD)
                    begin
                        phase_next = PH_DELTA;
                        emit = 1'b1;
                        res.field_a = b;
                        res.field_b = 8'hFF;
                    end
                    else
                        phase_next = PH_PARAM2;
                end
                PH_PARAM2:
                begin
                    phase_next = PH_DELTA;
                    emit = 1'b1;
                    res.field_a = g_reg[0];
                    res.field_b = b;
                end
                PH_META_TYPE:
                begin
                    cur_meta_next = b;
                    lcnt_next = '0;
                    phase_next = PH_META_LEN;
                end
                PH_META_LEN, PH_SYSEX_LEN:
                begin
                    len_next = vlq_acc;
                    lcnt_next = vlq_cont ? lc + 1'b1 : '0;
                    if (vlq_over)
                        n = ERR_OVERLONG;
                    else if (!vlq_cont)
                    begin
                        if (ph == PH_META_LEN && flen[3])
                        begin
                            if (vlq_acc != {25'd0, flen[2:0]})
                                n = ERR_META_LEN;
                            else if (flen[2:0] == 3'd0)
                            begin
                                phase_next = PH_DELTA;
                                emit = 1'b1;
                                res.kind = KIND_FIXED;
                            end
                            else
                            begin
                                fidx_next = 3'd0;
                                phase_next = PH_GATHER;
                            end
                        end
                        else
                        begin
                            phase_next = (vlq_acc != 28'd0) ? PH_PAYLOAD : PH_DELTA;
                            emit = 1'b1;
                            res.kind = (ph == PH_META_LEN) ? KIND_META_HDR :
                                       (cur_status_reg == 8'hF0) ? KIND_SYSEX :
                                       KIND_DIV_SYSEX;
                            res.wide_value = vlq_acc;
                            res.last_of_event = (vlq_acc == 28'd0);
                        end
                    end
                end
                PH_GATHER:
                begin
                    for (int i = 0; i < 5; i++)
                    begin
                        if (fidx_reg == 3'(i))
                            g_next[i] = b;
                    end
                    fidx_next = fidx_inc;
                    if (!flen[3] || fidx_inc >= flen[2:0])
                    begin
                        phase_next = PH_DELTA;
                        emit = 1'b1;
                        res.kind = KIND_FIXED;
                        unique case (cur_meta_reg)
                            META_SEQ:
                                res.wide_value = {12'd0, g_next[0], g_next[1]};
                            META_CHAN:
                                res.field_a = g_next[0];
                            META_TEMPO:
                                res.wide_value = {4'd0, g_next[0], g_next[1], g_next[2]};
                            META_SMPTE:
                            begin
                                res.field_a = {3'd0, g_next[0][4:0]};
                                res.field_b = g_next[1];
                                res.field_c = g_next[2];
                                res.field_d = g_next[3];
                                res.field_e = g_next[4];
                                res.wide_value = smpte_rate(g_next[0][6:5]);
                            end
                            META_TIMESIG:
                            begin
                                res.field_a = g_next[0];
                                res.field_b = g_next[1];
                                res.field_c = g_next[2];
                                res.field_d = g_next[3];
                            end
                            META_KEYSIG:
                            begin
                                res.field_a = g_next[0];
                                res.field_b = g_next[1];
                            end
                            default:
                                res.wide_value = 28'd0;
                        endcase
                    end
                end
                PH_PAYLOAD:
                begin
                    len_next = len_dec;
                    if (len_dec == 28'd0)
                        phase_next = PH_DELTA;
                    emit = 1'b1;
                    res.kind = KIND_PAYLOAD;
                    res.field_a = b;
                    res.last_of_event = (len_dec == 28'd0);
                end
                default:
                begin
                    phase_next = PH_DELTA;
                    lcnt_next = '0;
                end
            endcase
            if (n != ERR_NONE)
            begin
                halted_next = 1'b1;
                phase_next = PH_DELTA;
                lcnt_next = '0;
                emit = 1'b1;
                res = '0;
                res.kind = KIND_ERROR;
                res.error_code = n;
            end
            if (res.kind != KIND_ERROR && res.kind != KIND_CHANNEL)
                res.last_of_event = res.last_of_event || res.kind == KIND_FIXED;
            if (res.kind == KIND_CHANNEL || res.kind == KIND_ERROR)
                res.last_of_event = 1'b1;
            res.delta_ticks = delta_next;
            res.status_byte = cur_status_next;
            res.meta_kind = cur_meta_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DELTA;
            running_reg <= 8'h00;
            delta_reg <= '0;
            len_reg <= '0;
            lcnt_reg <= '0;
            cur_status_reg <= 8'h00;
            cur_meta_reg <= 8'h00;
            fidx_reg <= '0;
            for (int i = 0; i < 5; i++)
            begin
                g_reg[i] <= 8'h00;
            end
            halted_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                running_reg <= running_next;
                delta_reg <= delta_next;
                len_reg <= len_next;
                lcnt_reg <= lcnt_next;
                cur_status_reg <= cur_status_next;
                cur_meta_reg <= cur_meta_next;
                fidx_reg <= fidx_next;
                for (int i = 0; i < 5; i++)
                begin
                    g_reg[i] <= g_next[i];
                end
                halted_reg <= halted_next;
            end
            if (accept)
                out_valid_reg <= emit && !halted_reg | (emit && ts);
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
            out_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {1'b0, out_reg};

endmodule

### src/mtep_checker.sv
// port-level checker for the track event parser, bound to the top level
`timescale 1ns / 1ps
`include "midi_track_event_parser_core_macros.svh"
module mtep_checker
    import mtep_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [119:0] m_axis_tdata
);

    `MTEP_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    `MTEP_ASSERT_IMPL(a_ready, !m_axis_tvalid, s_axis_tready)
    `MTEP_ASSERT_IMPL(a_err_last, m_axis_tvalid && m_axis_tdata[2:0] == KIND_ERROR,
        m_axis_tdata[115] && m_axis_tdata[118:116] != ERR_NONE)
    `MTEP_ASSERT_IMPL(a_kind, m_axis_tvalid, m_axis_tdata[2:0] != 3'd7)

endmodule

bind midi_track_event_parser_core mtep_checker u_mtep_checker (
    .clk(clk),
    .rst_n(rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
